// ----- design/ffpp_pkg.sv -----
// Shared types and constants of the first-fit patch placer.
// No dependencies; used by ffpp_box_chk, first_fit_patch_placer and the testbench.
package ffpp_pkg;

    // coordinate width, wide enough for any map size in range plus a patch and gap
    localparam int CRD_W = 14;

    // request codes
    typedef enum logic [1:0] {
        OP_FRAME_START = 2'd0,
        OP_HEADER      = 2'd1,
        OP_BIT         = 2'd2,
        OP_FRAME_END   = 2'd3
    } t_op;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_MAP_WIDTH  = 2'd0,
        CFG_MIN_HEIGHT = 2'd1,
        CFG_BLOCK_RES  = 2'd2,
        CFG_SPACE      = 2'd3
    } t_cfg_idx;

    // result kinds
    localparam logic KIND_PLACE = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // configuration reset values
    localparam logic [10:0] RST_MAP_WIDTH  = 11'd1024;
    localparam logic [11:0] RST_MIN_HEIGHT = 12'd1024;
    localparam logic [4:0]  RST_BLOCK_RES  = 5'd4;
    localparam logic [3:0]  RST_SPACE      = 4'd1;

    // one box check: candidate box plus map bounds and gap
    typedef struct packed {
        logic [CRD_W-1:0] x;
        logic [CRD_W-1:0] y;
        logic [11:0]      bw;
        logic [11:0]      bh;
        logic [CRD_W-1:0] hgt;
        logic [CRD_W-1:0] wid;
        logic [7:0]       gap;
    } t_box_req;

    typedef struct packed {
        logic done;
        logic fit;
    } t_box_rsp;

endpackage

// ----- design/ffpp_occ_mem.sv -----
// Occupancy map memory: one row of cells per word, row clear or single-cell write,
// one registered row read. Depends on nothing else.
module ffpp_occ_mem #(
    parameter int MAX_MAP_WIDTH  = 1024,
    parameter int MAX_MAP_HEIGHT = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_clr,
    input  logic                              i_we,
    input  logic [$clog2(MAX_MAP_HEIGHT)-1:0] i_wr_row,
    input  logic [$clog2(MAX_MAP_WIDTH)-1:0]  i_wr_col,
    input  logic                              i_wr_bit,
    input  logic                              i_rd_en,
    input  logic [$clog2(MAX_MAP_HEIGHT)-1:0] i_rd_row,
    output logic [MAX_MAP_WIDTH-1:0]          o_rd_data
);

    logic [MAX_MAP_WIDTH-1:0] r_mem [MAX_MAP_HEIGHT];

    // write port: whole-row clear has priority over a cell write
    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_mem[i_wr_row] <= '0;
        end else if (i_we) begin
            r_mem[i_wr_row][i_wr_col] <= i_wr_bit;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_row];
        end
    end

endmodule

// ----- design/ffpp_box_chk.sv -----
// Box check unit: bounds test, gap clipping and a row-by-row scan of the map for set cells.
// Depends on ffpp_pkg; reads the occupancy memory through its read port.
module ffpp_box_chk #(
    parameter int MAX_MAP_WIDTH  = 1024,
    parameter int MAX_MAP_HEIGHT = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  ffpp_pkg::t_box_req                i_req,
    output ffpp_pkg::t_box_rsp                o_rsp,
    output logic                              o_rd_en,
    output logic [$clog2(MAX_MAP_HEIGHT)-1:0] o_rd_row,
    input  logic [MAX_MAP_WIDTH-1:0]          i_rd_data
);
    import ffpp_pkg::*;

    localparam int RW = $clog2(MAX_MAP_HEIGHT);

    typedef enum logic [4:0] {
        C_IDLE  = 5'b00001,
        C_BOUND = 5'b00010,
        C_MASK  = 5'b00100,
        C_RD    = 5'b01000,
        C_CHK   = 5'b10000
    } t_cstate;

    t_cstate                  r_state, n_state;
    t_box_req                 r_req;
    logic [CRD_W-1:0]         r_x0, r_x1, r_y1, r_row;
    logic [MAX_MAP_WIDTH-1:0] r_mask;
    logic                     r_done, r_fit;

    logic [CRD_W-1:0] xe, ye, xg, yg, x0, y0, x1, y1;
    logic             inrange, hit, last_row;

    // bounds and gap-grown box clipped at the map edges
    always_comb begin
        xe      = r_req.x + CRD_W'(r_req.bw);
        ye      = r_req.y + CRD_W'(r_req.bh);
        xg      = xe + CRD_W'(r_req.gap);
        yg      = ye + CRD_W'(r_req.gap);
        inrange = (xe <= r_req.wid) && (ye <= r_req.hgt);
        x0      = (r_req.x > CRD_W'(r_req.gap)) ? r_req.x - CRD_W'(r_req.gap) : '0;
        y0      = (r_req.y > CRD_W'(r_req.gap)) ? r_req.y - CRD_W'(r_req.gap) : '0;
        x1      = (xg > r_req.wid) ? r_req.wid : xg;
        y1      = (yg > r_req.hgt) ? r_req.hgt : yg;
    end

    assign hit      = |(i_rd_data & r_mask);
    assign last_row = (r_row + CRD_W'(1)) == r_y1;
    assign o_rd_en  = (r_state == C_RD);
    assign o_rd_row = r_row[RW-1:0];
    assign o_rsp    = '{done: r_done, fit: r_fit};

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE:  if (i_start) n_state = C_BOUND;
            C_BOUND: n_state = inrange ? C_MASK : C_IDLE;
            C_MASK:  n_state = C_RD;
            C_RD:    n_state = C_CHK;
            C_CHK:   n_state = (hit || last_row) ? C_IDLE : C_RD;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= ((r_state == C_BOUND) && !inrange) ||
                       ((r_state == C_CHK) && (hit || last_row));
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_fit <= (r_state == C_CHK) && !hit;
        if (r_state == C_IDLE && i_start) begin
            r_req <= i_req;
        end
        if (r_state == C_BOUND) begin
            r_x0  <= x0;
            r_x1  <= x1;
            r_y1  <= y1;
            r_row <= y0;
        end
        if (r_state == C_MASK) begin
            for (int i = 0; i < MAX_MAP_WIDTH; i++) begin
                r_mask[i] <= (CRD_W'(i) >= r_x0) && (CRD_W'(i) < r_x1);
            end
        end
        if (r_state == C_CHK) begin
            r_row <= r_row + CRD_W'(1);
        end
    end

endmodule

// ----- design/first_fit_patch_placer.sv -----
// First-fit patch placer: search sequencer, configuration, patch bit writer, result register.
// Depends on ffpp_pkg, ffpp_occ_mem and ffpp_box_chk.
//
// Keeps a one-bit occupancy map (MAX_MAP_WIDTH x MAX_MAP_HEIGHT cells, one row per memory
// word) and places patches first-fit on a grid of (1+patch_space)*block_res cells, trying
// each position as given and then transposed, and doubling the map height when nothing
// fits. After reset and after every frame_start the map is cleared one row per cycle, and
// the input is stalled until every row has been cleared. A header holds the input for the
// whole search: each orientation tried runs a bounds check and, if the box is in range, a
// mask build, then one memory read and one masked compare of the shared box check unit
// per map row under the gap-grown box; the scan ends at the first set cell. Configuration
// writes are taken in any cycle and must only be issued while idle.
module first_fit_patch_placer #(
    parameter int MAX_MAP_WIDTH  = 1024,
    parameter int MAX_MAP_HEIGHT = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [11:0] i_patch_width,
    input  logic [11:0] i_patch_height,
    input  logic        i_occ_bit,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [9:0]  o_pos_x_blocks,
    output logic [10:0] o_pos_y_blocks,
    output logic        o_swapped,
    output logic        o_failed,
    output logic [11:0] o_map_height,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);
    import ffpp_pkg::*;

    localparam int RW = $clog2(MAX_MAP_HEIGHT);
    localparam int CX = $clog2(MAX_MAP_WIDTH);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CLEAR = 4'b0010,
        S_TRY   = 4'b0100,
        S_WAIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [10:0] r_map_width;
    logic [11:0] r_min_height;
    logic [4:0]  r_block_res;
    logic [3:0]  r_space;

    // map and search state
    logic [RW-1:0]    r_clr_row;
    logic [CRD_W-1:0] r_cur_height, r_max_bottom, r_hgt;
    logic [CRD_W-1:0] r_x, r_y, r_xb, r_yb;
    logic             r_orient;
    logic [11:0]      r_pw, r_ph;

    // pending patch for bit writes
    logic [CRD_W-1:0] r_corner_x, r_corner_y;
    logic             r_sw, r_failed;
    logic [11:0]      r_cur_w, r_cur_h, r_bit_col, r_bit_row;

    // result register
    logic        r_out_vld, r_kind, r_o_sw, r_o_fail;
    logic [9:0]  r_o_x;
    logic [10:0] r_o_y;
    logic [11:0] r_o_h;

    // effective (clamped) configuration
    logic [CRD_W-1:0] eff_wid, eff_minh, step, x_nx, y_nx, mx, my, bottom, rep;
    logic [4:0]       eff_res;
    logic [3:0]       eff_space;
    logic [7:0]       gap;
    logic             in_acc, out_take, cfg_acc, x_wrap, y_wrap, grow_ok;
    logic             bit_live, bit_we, empty_hdr;
    t_op              op;
    t_box_req         box_req;
    t_box_rsp         box_rsp;
    logic             rd_en;
    logic [RW-1:0]    rd_row;
    logic [MAX_MAP_WIDTH-1:0] rd_data;

    always_comb begin
        if (r_map_width == '0) eff_wid = CRD_W'(1);
        else if (CRD_W'(r_map_width) > CRD_W'(MAX_MAP_WIDTH)) eff_wid = CRD_W'(MAX_MAP_WIDTH);
        else eff_wid = CRD_W'(r_map_width);
        if (r_min_height == '0) eff_minh = CRD_W'(1);
        else if (CRD_W'(r_min_height) > CRD_W'(MAX_MAP_HEIGHT))
            eff_minh = CRD_W'(MAX_MAP_HEIGHT);
        else eff_minh = CRD_W'(r_min_height);
        if (r_block_res == '0) eff_res = 5'd1;
        else if (r_block_res > 5'd16) eff_res = 5'd16;
        else eff_res = r_block_res;
        eff_space = (r_space > 4'd8) ? 4'd8 : r_space;
        gap  = 8'(eff_space) * 8'(eff_res);
        step = CRD_W'(gap) + CRD_W'(eff_res);
    end

    // handshakes
    assign op          = t_op'(i_op);
    assign o_in_stall  = (r_state != S_IDLE) || (r_out_vld && i_out_stall);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_take    = r_out_vld && !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid;
    assign empty_hdr   = (i_patch_width == '0) || (i_patch_height == '0);

    // next search position
    assign x_nx    = r_x + step;
    assign y_nx    = r_y + step;
    assign x_wrap  = x_nx >= eff_wid;
    assign y_wrap  = y_nx >= r_hgt;
    assign grow_ok = {1'b0, r_hgt, 1'b0} <= (CRD_W + 2)'(MAX_MAP_HEIGHT);
    assign bottom  = r_y + CRD_W'(r_orient ? r_pw : r_ph);
    assign rep     = (r_max_bottom > eff_minh) ? r_max_bottom : eff_minh;

    // patch bit target cell
    assign bit_live = !r_failed && (r_cur_w != '0) && (r_bit_row < r_cur_h);
    assign mx = r_corner_x + CRD_W'(r_sw ? r_bit_row : r_bit_col);
    assign my = r_corner_y + CRD_W'(r_sw ? r_bit_col : r_bit_row);
    assign bit_we = in_acc && (op == OP_BIT) && bit_live &&
                    (mx < CRD_W'(MAX_MAP_WIDTH)) && (my < CRD_W'(MAX_MAP_HEIGHT));

    // box request to the shared check unit
    assign box_req = '{x: r_x, y: r_y,
                       bw: r_orient ? r_ph : r_pw,
                       bh: r_orient ? r_pw : r_ph,
                       hgt: r_hgt, wid: eff_wid, gap: gap};

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && op == OP_FRAME_START) n_state = S_CLEAR;
                else if (in_acc && op == OP_HEADER && !empty_hdr) n_state = S_TRY;
            end
            S_CLEAR: if (r_clr_row == RW'(MAX_MAP_HEIGHT - 1)) n_state = S_IDLE;
            S_TRY:   n_state = S_WAIT;
            S_WAIT: begin
                if (box_rsp.done) begin
                    if (box_rsp.fit) n_state = S_IDLE;
                    else if (!r_orient) n_state = S_TRY;
                    else if (!x_wrap || !y_wrap || grow_ok) n_state = S_TRY;
                    else n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_row    <= '0;
            r_out_vld    <= 1'b0;
            r_map_width  <= RST_MAP_WIDTH;
            r_min_height <= RST_MIN_HEIGHT;
            r_block_res  <= RST_BLOCK_RES;
            r_space      <= RST_SPACE;
            r_cur_height <= CRD_W'(RST_MIN_HEIGHT);
            r_max_bottom <= '0;
            r_cur_w      <= '0;
            r_failed     <= 1'b0;
        end else begin
            r_state <= n_state;
            // configuration write
            if (cfg_acc) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data[10:0];
                    CFG_MIN_HEIGHT: r_min_height <= i_cfg_data;
                    CFG_BLOCK_RES:  r_block_res  <= i_cfg_data[4:0];
                    CFG_SPACE:      r_space      <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            // clear sweep
            if (r_state == S_CLEAR) r_clr_row <= r_clr_row + RW'(1);
            // result valid
            if ((in_acc && (op == OP_FRAME_END || (op == OP_HEADER && empty_hdr))) ||
                (n_state == S_IDLE && r_state == S_WAIT)) begin
                r_out_vld <= 1'b1;
            end else if (out_take) begin
                r_out_vld <= 1'b0;
            end
            // request handling
            if (in_acc) begin
                unique case (op)
                    OP_FRAME_START: begin
                        r_clr_row    <= '0;
                        r_cur_height <= eff_minh;
                        r_max_bottom <= '0;
                        r_cur_w      <= '0;
                        r_failed     <= 1'b0;
                    end
                    OP_HEADER: begin
                        r_cur_w  <= '0;
                        r_failed <= empty_hdr;
                    end
                    default: ;
                endcase
            end
            // search outcome
            if (r_state == S_WAIT && box_rsp.done) begin
                if (box_rsp.fit) begin
                    r_cur_height <= r_hgt;
                    r_cur_w      <= r_pw;
                    if (bottom > r_max_bottom) r_max_bottom <= bottom;
                end else if (r_orient && x_wrap && y_wrap && !grow_ok) begin
                    r_cur_height <= r_hgt;
                    r_failed     <= 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc && op == OP_HEADER) begin
            r_pw       <= i_patch_width;
            r_ph       <= i_patch_height;
            r_hgt      <= r_cur_height;
            r_x        <= '0;
            r_y        <= '0;
            r_xb       <= '0;
            r_yb       <= '0;
            r_orient   <= 1'b0;
            r_corner_x <= '0;
            r_corner_y <= '0;
            r_sw       <= 1'b0;
            r_cur_h    <= '0;
            r_bit_col  <= '0;
            r_bit_row  <= '0;
        end
        // result register loads
        if (in_acc && op == OP_FRAME_END) begin
            r_kind   <= KIND_FRAME;
            r_o_x    <= '0;
            r_o_y    <= '0;
            r_o_sw   <= 1'b0;
            r_o_fail <= 1'b0;
            r_o_h    <= rep[11:0];
        end
        if (in_acc && op == OP_HEADER && empty_hdr) begin
            r_kind   <= KIND_PLACE;
            r_o_x    <= '0;
            r_o_y    <= '0;
            r_o_sw   <= 1'b0;
            r_o_fail <= 1'b1;
            r_o_h    <= r_cur_height[11:0];
        end
        // step through positions
        if (r_state == S_WAIT && box_rsp.done) begin
            if (box_rsp.fit) begin
                r_corner_x <= r_x;
                r_corner_y <= r_y;
                r_sw       <= r_orient;
                r_cur_h    <= r_ph;
                r_kind     <= KIND_PLACE;
                r_o_x      <= r_xb[9:0];
                r_o_y      <= r_yb[10:0];
                r_o_sw     <= r_orient;
                r_o_fail   <= 1'b0;
                r_o_h      <= r_hgt[11:0];
            end else if (!r_orient) begin
                r_orient <= 1'b1;
            end else begin
                r_orient <= 1'b0;
                if (!x_wrap) begin
                    r_x  <= x_nx;
                    r_xb <= r_xb + CRD_W'(eff_space) + CRD_W'(1);
                end else begin
                    r_x  <= '0;
                    r_xb <= '0;
                    if (!y_wrap) begin
                        r_y  <= y_nx;
                        r_yb <= r_yb + CRD_W'(eff_space) + CRD_W'(1);
                    end else if (grow_ok) begin
                        r_y   <= '0;
                        r_yb  <= '0;
                        r_hgt <= {r_hgt[CRD_W-2:0], 1'b0};
                    end else begin
                        r_kind   <= KIND_PLACE;
                        r_o_x    <= '0;
                        r_o_y    <= '0;
                        r_o_sw   <= 1'b0;
                        r_o_fail <= 1'b1;
                        r_o_h    <= r_hgt[11:0];
                    end
                end
            end
        end
        // patch bit counters
        if (in_acc && op == OP_BIT && bit_live) begin
            if (r_bit_col + 12'd1 >= r_cur_w) begin
                r_bit_col <= '0;
                r_bit_row <= r_bit_row + 12'd1;
            end else begin
                r_bit_col <= r_bit_col + 12'd1;
            end
        end
    end

    // occupancy map
    ffpp_occ_mem #(
        .MAX_MAP_WIDTH  (MAX_MAP_WIDTH),
        .MAX_MAP_HEIGHT (MAX_MAP_HEIGHT)
    ) u_mem (
        .i_clk     (i_clk),
        .i_clr     (r_state == S_CLEAR),
        .i_we      (bit_we),
        .i_wr_row  ((r_state == S_CLEAR) ? r_clr_row : my[RW-1:0]),
        .i_wr_col  (mx[CX-1:0]),
        .i_wr_bit  (i_occ_bit),
        .i_rd_en   (rd_en),
        .i_rd_row  (rd_row),
        .o_rd_data (rd_data)
    );

    // shared box check unit
    ffpp_box_chk #(
        .MAX_MAP_WIDTH  (MAX_MAP_WIDTH),
        .MAX_MAP_HEIGHT (MAX_MAP_HEIGHT)
    ) u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == S_TRY),
        .i_req     (box_req),
        .o_rsp     (box_rsp),
        .o_rd_en   (rd_en),
        .o_rd_row  (rd_row),
        .i_rd_data (rd_data)
    );

    // outputs
    assign o_out_valid    = r_out_vld;
    assign o_kind         = r_kind;
    assign o_pos_x_blocks = r_o_x;
    assign o_pos_y_blocks = r_o_y;
    assign o_swapped      = r_o_sw;
    assign o_failed       = r_o_fail;
    assign o_map_height   = r_o_h;

endmodule

// ----- tb/sv/first_fit_patch_placer_tb.sv -----
// Self-checking testbench of the first-fit patch placer.
// Depends on ffpp_pkg and first_fit_patch_placer; keeps its own occupancy map to predict
// placements and frame end heights, and checks each result against the oldest prediction.
module first_fit_patch_placer_tb;
    import ffpp_pkg::*;

    localparam int MAXW = 1024;
    localparam int MAXH = 2048;

    typedef struct {
        logic        kind;
        logic [9:0]  px;
        logic [10:0] py;
        logic        sw;
        logic        fl;
        logic [11:0] mh;
    } t_place_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_op = OP_FRAME_START;
    logic [11:0] i_patch_width = '0;
    logic [11:0] i_patch_height = '0;
    logic        i_occ_bit = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_kind;
    logic [9:0]  o_pos_x_blocks;
    logic [10:0] o_pos_y_blocks;
    logic        o_swapped;
    logic        o_failed;
    logic [11:0] o_map_height;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_MAP_WIDTH;
    logic [11:0] i_cfg_data = '0;

    first_fit_patch_placer dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    bit [MAXW-1:0] occ_map [MAXH];
    int reg_width = 1024, reg_min_h = 1024, reg_res = 4, reg_space = 1;
    int cur_height, max_bottom, pend_w, pend_h, col_cnt, row_cnt, corner_x, corner_y;
    bit pend_swap, pend_fail;

    t_place_res placements_due [$];
    int  errors = 0;
    int  n_items = 0, n_headers = 0, n_fails = 0, n_swaps = 0, n_frames = 0, n_checked = 0;
    int  out_hold = 0;
    bit  idle_on = 1'b1;

    function automatic int clampi(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int eff_width();  return clampi(reg_width, 1, MAXW); endfunction
    function automatic int eff_min_h();  return clampi(reg_min_h, 1, MAXH); endfunction
    function automatic int eff_res();    return clampi(reg_res, 1, 16);     endfunction
    function automatic int eff_space();  return clampi(reg_space, 0, 8);    endfunction

    function automatic void clear_pending();
        pend_w = 0; pend_h = 0; col_cnt = 0; row_cnt = 0;
        corner_x = 0; corner_y = 0; pend_swap = 0; pend_fail = 0;
    endfunction

    function automatic void clear_frame();
        foreach (occ_map[r]) occ_map[r] = '0;
        cur_height = eff_min_h();
        max_bottom = 0;
        clear_pending();
    endfunction

    // box inside the map and its gap-grown, edge-clipped area free of set cells
    function automatic bit box_free(int x, int y, int bw, int bh, int hgt, int wid, int gap);
        int x0, y0, x1, y1;
        logic [MAXW-1:0] one, mask;
        if (bw > wid || x > wid - bw || bh > hgt || y > hgt - bh) return 1'b0;
        x0 = x - (gap < x ? gap : x);
        y0 = y - (gap < y ? gap : y);
        x1 = x + bw + (gap < wid - (x + bw) ? gap : wid - (x + bw));
        y1 = y + bh + (gap < hgt - (y + bh) ? gap : hgt - (y + bh));
        one = 1;
        mask = (one << (x1 - x0)) - one;
        for (int r = y0; r < y1; r++)
            if (((occ_map[r] >> x0) & mask) != '0) return 1'b0;
        return 1'b1;
    endfunction

    // first-fit scan at one map height
    function automatic bit scan_height(int hgt, int w, int h, output int fx, output int fy,
                                       output bit sw);
        int wid, step, gap;
        wid = eff_width();
        step = (1 + eff_space()) * eff_res();
        gap = eff_space() * eff_res();
        fx = 0; fy = 0; sw = 0;
        for (int y = 0; y < hgt; y += step)
            for (int x = 0; x < wid; x += step) begin
                if (box_free(x, y, w, h, hgt, wid, gap)) begin
                    fx = x; fy = y; sw = 0;
                    return 1'b1;
                end
                if (box_free(x, y, h, w, hgt, wid, gap)) begin
                    fx = x; fy = y; sw = 1;
                    return 1'b1;
                end
            end
        return 1'b0;
    endfunction

    // update the predicted placer state for one accepted request
    function automatic void predict_request(logic [1:0] op, int w, int h, bit b);
        t_place_res res;
        int hgt, fx, fy, mx, my;
        bit sw, found;
        res = '{KIND_PLACE, 0, 0, 0, 0, 0};
        found = 0;
        case (op)
            OP_FRAME_START: begin
                clear_frame();
            end
            OP_HEADER: begin
                clear_pending();
                hgt = cur_height;
                if (w != 0 && h != 0) begin
                    forever begin
                        if (scan_height(hgt, w, h, fx, fy, sw)) begin
                            found = 1;
                            break;
                        end
                        if (hgt * 2 > MAXH) break;
                        hgt *= 2;
                    end
                    cur_height = hgt;
                end
                if (found) begin
                    corner_x = fx; corner_y = fy; pend_swap = sw;
                    pend_w = w; pend_h = h;
                    if (fy + (sw ? w : h) > max_bottom) max_bottom = fy + (sw ? w : h);
                    res.px = 10'(fx / eff_res());
                    res.py = 11'(fy / eff_res());
                    res.sw = sw;
                    n_swaps += sw;
                end else begin
                    pend_fail = 1;
                    res.fl = 1;
                    n_fails++;
                end
                res.mh = 12'(cur_height);
                placements_due = {placements_due, res};
                n_headers++;
            end
            OP_BIT: begin
                if (!pend_fail && pend_w != 0 && row_cnt < pend_h) begin
                    mx = pend_swap ? corner_x + row_cnt : corner_x + col_cnt;
                    my = pend_swap ? corner_y + col_cnt : corner_y + row_cnt;
                    if (mx < MAXW && my < MAXH) occ_map[my][mx] = b;
                    col_cnt++;
                    if (col_cnt >= pend_w) begin
                        col_cnt = 0;
                        row_cnt++;
                    end
                end
            end
            default: begin
                res.kind = KIND_FRAME;
                res.mh = 12'(max_bottom > eff_min_h() ? max_bottom : eff_min_h());
                placements_due = {placements_due, res};
                n_frames++;
            end
        endcase
    endfunction

    // send one request, wait for it to be taken, then idle a random while if idling is on
    task automatic send_request(logic [1:0] op, int w = 0, int h = 0, bit b = 0);
        int gap;
        i_in_valid <= 1'b1;
        i_op <= op;
        i_patch_width <= 12'(w);
        i_patch_height <= 12'(h);
        i_occ_bit <= b;
        do @(posedge i_clk); while (o_in_stall);
        predict_request(op, w & 12'hFFF, h & 12'hFFF, b);
        n_items++;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // header followed by its full row-major bit stream
    task automatic send_patch(int w, int h);
        send_request(OP_HEADER, w, h);
        for (int i = 0; i < w * h; i++) send_request(OP_BIT, 0, 0, $urandom_range(0, 1));
    endtask

    // let the block go idle: all results back, plus a wait longer than a full map clear
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (placements_due.size() != 0) @(posedge i_clk);
        repeat (MAXH + 64) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 12'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MAP_WIDTH:  reg_width = val & 12'h7FF;
            CFG_MIN_HEIGHT: reg_min_h = val & 12'hFFF;
            CFG_BLOCK_RES:  reg_res = val & 12'h1F;
            default:        reg_space = val & 12'hF;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(int w, int mh, int res, int sp);
        drain();
        write_reg(CFG_MAP_WIDTH, w);
        write_reg(CFG_MIN_HEIGHT, mh);
        write_reg(CFG_BLOCK_RES, res);
        write_reg(CFG_SPACE, sp);
    endtask

    // result checker and random output stall
    always @(posedge i_clk) begin
        t_place_res e;
        if (o_out_valid && !i_out_stall) begin
            n_checked++;
            if (placements_due.size() == 0) begin
                $display("%0t: unexpected result kind=%0d map_height=%0d", $time, o_kind,
                         o_map_height);
                errors++;
            end else begin
                e = placements_due.pop_front();
                if (o_kind !== e.kind || o_pos_x_blocks !== e.px || o_pos_y_blocks !== e.py ||
                    o_swapped !== e.sw || o_failed !== e.fl || o_map_height !== e.mh) begin
                    $display("%0t: expected kind=%0d x=%0d y=%0d sw=%0d fail=%0d h=%0d",
                             $time, e.kind, e.px, e.py, e.sw, e.fl, e.mh);
                    $display("%0t:   actual kind=%0d x=%0d y=%0d sw=%0d fail=%0d h=%0d",
                             $time, o_kind, o_pos_x_blocks, o_pos_y_blocks, o_swapped,
                             o_failed, o_map_height);
                    errors++;
                end
            end
            out_hold = idle_on ? $urandom_range(0, 5) : 0;
            i_out_stall <= (out_hold > 0);
        end else if (out_hold > 0) begin
            out_hold--;
            i_out_stall <= (out_hold > 0);
        end
    end

    // reset configuration: first headers land at the origin and the grid
    task automatic test_reset_defaults();
        send_patch(3, 2);
        send_patch(2, 5);
        send_request(OP_FRAME_END);
    endtask

    // field extremes, empty patches, failures, transposition
    task automatic test_extremes();
        set_config(1024, 2048, 16, 8);
        send_request(OP_FRAME_START);
        send_request(OP_HEADER, 2048, 2048);
        send_request(OP_HEADER, 4095, 1);
        send_request(OP_HEADER, 0, 5);
        send_request(OP_HEADER, 7, 0);
        send_request(OP_HEADER, 0, 0);
        send_patch(1, 1);
        send_request(OP_HEADER, 1024, 16);
        send_request(OP_FRAME_END);
        // narrow map forces transposed placement
        set_config(4, 8, 1, 0);
        send_request(OP_FRAME_START);
        send_patch(6, 2);
        send_patch(1, 3);
        send_request(OP_FRAME_END);
        // out-of-range register values act as the nearest bound
        set_config(0, 0, 0, 15);
        send_request(OP_FRAME_START);
        send_patch(1, 1);
        send_request(OP_HEADER, 2, 1);
        send_request(OP_FRAME_END);
        set_config(2047, 4095, 31, 0);
        send_request(OP_FRAME_START);
        send_patch(2, 2);
        send_request(OP_FRAME_END);
    endtask

    // stray bits, abandoned bit streams, frame end then more headers
    task automatic test_stray_and_abandon();
        set_config(16, 8, 1, 1);
        send_request(OP_FRAME_START);
        send_request(OP_BIT, 0, 0, 1);
        send_request(OP_FRAME_END);
        send_request(OP_HEADER, 3, 3);
        for (int i = 0; i < 4; i++) send_request(OP_BIT, 0, 0, 1);
        send_patch(2, 2);
        for (int i = 0; i < 3; i++) send_request(OP_BIT, 0, 0, 1);
        send_request(OP_FRAME_END);
        send_patch(4, 1);
        send_request(OP_HEADER, 40, 40);
        send_request(OP_BIT, 0, 0, 1);
        send_request(OP_FRAME_END);
    endtask

    // random frames of well-formed patches with some noise, over several settings
    task automatic test_random(int target);
        int w_tab [5] = '{32, 64, 24, 1, 8};
        int h_tab [5] = '{16, 4, 32, 1, 8};
        int r_tab [5] = '{1, 2, 1, 1, 2};
        int s_tab [5] = '{0, 1, 2, 0, 3};
        int d_tab [5] = '{6, 8, 5, 1, 4};
        int ph, nbits, pw, phh, r;
        ph = 0;
        while (n_items < target) begin
            set_config(w_tab[ph % 5], h_tab[ph % 5], r_tab[ph % 5], s_tab[ph % 5]);
            idle_on = (ph % 3 != 2);
            for (int f = 0; f < 3 && n_items < target; f++) begin
                send_request(OP_FRAME_START);
                for (int p = 0; p < 8; p++) begin
                    pw = $urandom_range(1, d_tab[ph % 5]);
                    phh = $urandom_range(1, d_tab[ph % 5]);
                    r = $urandom_range(0, 9);
                    if (r == 0) begin
                        // noise request
                        send_request(t_op'($urandom_range(1, 3)), pw, phh, $urandom_range(0, 1));
                    end else if (r == 1) begin
                        // truncated or overlong bit stream
                        send_request(OP_HEADER, pw, phh);
                        nbits = $urandom_range(0, pw * phh + 3);
                        for (int i = 0; i < nbits; i++)
                            send_request(OP_BIT, 0, 0, $urandom_range(0, 1));
                    end else begin
                        send_patch(pw, phh);
                    end
                end
                send_request(OP_FRAME_END);
            end
            ph++;
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        clear_frame();
        test_reset_defaults();
        test_extremes();
        test_stray_and_abandon();
        test_random(1250);
        drain();
        $display("Sent %0d requests: %0d headers (%0d failed, %0d transposed), %0d frame ends.",
                 n_items, n_headers, n_fails, n_swaps, n_frames);
        $display("Compared %0d results over several map, grid and gap settings.", n_checked);
        if (errors == 0 && placements_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- first_fit_patch_placer.f -----
design/ffpp_pkg.sv
design/ffpp_occ_mem.sv
design/ffpp_box_chk.sv
design/first_fit_patch_placer.sv
tb/sv/first_fit_patch_placer_tb.sv
